// ===== sv/pcca_pkg.sv =====
`default_nettype none

package pcca_pkg;

  localparam int unsigned MASK_W   = 64;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CPU_W    = 6;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned LANES    = 8;
  localparam int unsigned LANE_W   = MASK_W / LANES;
  localparam int unsigned LANE_CNT_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ONLINE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ISOLATED = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_CLAIM       = 2'd0,
    OP_RELEASE     = 2'd1,
    OP_RELEASE_ALL = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_NOT_ONLINE = 3'd1,
    STAT_CLAIMED    = 3'd2,
    STAT_LAST_FREE  = 3'd3,
    STAT_NONE       = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT_PART,
    S_CNT_SUM,
    S_EXEC,
    S_FIN_PART,
    S_FIN_SUM
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic load_pre_part;
    logic load_pre_sum;
    logic exec;
    logic load_post_part;
    logic load_out;
  } pcca_cmd_t;

  typedef logic [LANE_CNT_W-1:0] lane_cnt_t;
  typedef lane_cnt_t [LANES-1:0] lane_vec_t;

  function automatic lane_cnt_t pop_lane(input logic [LANE_W-1:0] v);
    lane_cnt_t n;
    n = '0;
    for (int i = 0; i < LANE_W; i++) begin
      n = n + LANE_CNT_W'(v[i]);
    end
    return n;
  endfunction

  function automatic lane_vec_t pop_lanes(input logic [MASK_W-1:0] v);
    lane_vec_t p;
    for (int l = 0; l < LANES; l++) begin
      p[l] = pop_lane(v[l*LANE_W +: LANE_W]);
    end
    return p;
  endfunction

  function automatic logic [CNT_W-1:0] sum_lanes(input lane_vec_t p);
    logic [CNT_W-1:0] s;
    s = '0;
    for (int l = 0; l < LANES; l++) begin
      s = s + CNT_W'(p[l]);
    end
    return s;
  endfunction

  // lowest set bit, zero when none
  function automatic logic [CPU_W-1:0] lowest_idx(input logic [MASK_W-1:0] v);
    logic [CPU_W-1:0] idx;
    idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = CPU_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pcca_ctrl.sv =====
`default_nettype none

module pcca_ctrl
  import pcca_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output pcca_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_CNT_PART;
        end
      end
      S_CNT_PART: begin
        cmd_o.load_pre_part = 1'b1;
        state_d             = S_CNT_SUM;
      end
      S_CNT_SUM: begin
        cmd_o.load_pre_sum = 1'b1;
        state_d            = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_FIN_PART;
      end
      S_FIN_PART: begin
        cmd_o.load_post_part = 1'b1;
        state_d              = S_FIN_SUM;
      end
      S_FIN_SUM: begin
        // wait for a free output slot
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/pcca_datapath.sv =====
`default_nettype none

module pcca_datapath
  import pcca_pkg::*;
#(
  parameter int unsigned NUM_CPUS = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pcca_cmd_t            cmd_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [MASK_W-1:0]    cfg_data_i,
  input  wire logic [OP_W-1:0]      op_i,
  input  wire logic                 has_request_i,
  input  wire logic [CPU_W-1:0]     target_cpu_i,
  input  wire logic                 prefer_isolated_i,
  input  wire logic                 avoid_first_cpu_i,
  output logic                      granted_o,
  output logic [CPU_W-1:0]          granted_cpu_o,
  output logic                      on_isolated_cpu_o,
  output logic [STAT_W-1:0]         status_o,
  output logic [CNT_W-1:0]          free_after_o,
  output logic [CNT_W-1:0]          released_count_o
);

  logic [NUM_CPUS-1:0] online_q, isolated_q;
  logic [NUM_CPUS-1:0] map_q, map_d;

  // latched item
  logic [OP_W-1:0]  op_q;
  logic             has_req_q, pref_q, avoid_q;
  logic [CPU_W-1:0] tgt_q;

  lane_vec_t        part_free_q, part_rel_q;
  logic [CNT_W-1:0] nfree_q, relall_q;

  logic             res_granted_q, res_granted_d;
  logic [CPU_W-1:0] res_cpu_q, res_cpu_d;
  logic             res_iso_q, res_iso_d;
  status_e          res_stat_q, res_stat_d;
  logic [CNT_W-1:0] res_rel_q, res_rel_d;

  logic [MASK_W-1:0] online_x, iso_x, map_x, free_x;
  logic [MASK_W-1:0] pick_iso, pick_avoid, pick;
  logic              tgt_ok;

  assign online_x = MASK_W'(online_q);
  assign iso_x    = MASK_W'(isolated_q);
  assign map_x    = MASK_W'(map_q);
  assign free_x   = online_x & ~map_x;
  assign tgt_ok   = (CNT_W'(tgt_q) < CNT_W'(NUM_CPUS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      online_q   <= NUM_CPUS'(1);
      isolated_q <= '0;
      map_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_ONLINE:   online_q   <= cfg_data_i[NUM_CPUS-1:0];
          REG_ISOLATED: isolated_q <= cfg_data_i[NUM_CPUS-1:0];
          default: ;
        endcase
      end
      map_q <= map_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q      <= op_i;
      has_req_q <= has_request_i;
      tgt_q     <= target_cpu_i;
      pref_q    <= prefer_isolated_i;
      avoid_q   <= avoid_first_cpu_i;
    end
    if (cmd_i.load_pre_part) begin
      part_free_q <= pop_lanes(free_x);
      part_rel_q  <= pop_lanes(map_x & online_x);
    end else if (cmd_i.load_post_part) begin
      part_free_q <= pop_lanes(free_x);
    end
    if (cmd_i.load_pre_sum) begin
      nfree_q  <= sum_lanes(part_free_q);
      relall_q <= sum_lanes(part_rel_q);
    end
    if (cmd_i.exec) begin
      res_granted_q <= res_granted_d;
      res_cpu_q     <= res_cpu_d;
      res_iso_q     <= res_iso_d;
      res_stat_q    <= res_stat_d;
      res_rel_q     <= res_rel_d;
    end
    if (cmd_i.load_out) begin
      granted_o         <= res_granted_q;
      granted_cpu_o     <= res_cpu_q;
      on_isolated_cpu_o <= res_iso_q;
      status_o          <= res_stat_q;
      free_after_o      <= sum_lanes(part_free_q);
      released_count_o  <= res_rel_q;
    end
  end

  // automatic pick order: isolated (if preferred), then not resource 0 (if avoided), then anything free
  assign pick_iso   = free_x & iso_x;
  assign pick_avoid = avoid_q ? (free_x & ~MASK_W'(1)) : free_x;

  always_comb begin
    if (pref_q && (pick_iso != '0)) begin
      pick = pick_iso;
    end else if (pick_avoid != '0) begin
      pick = pick_avoid;
    end else begin
      pick = free_x;
    end
  end

  always_comb begin
    logic [MASK_W-1:0] nxt;
    nxt           = map_x;
    res_granted_d = 1'b0;
    res_cpu_d     = '0;
    res_stat_d    = STAT_OK;
    res_rel_d     = '0;
    unique case (op_e'(op_q))
      OP_CLAIM: begin
        if (has_req_q) begin
          if (!tgt_ok || !online_x[tgt_q]) begin
            res_stat_d = STAT_NOT_ONLINE;
          end else if (map_x[tgt_q]) begin
            res_stat_d = STAT_CLAIMED;
          end else if (nfree_q < CNT_W'(2)) begin
            res_stat_d = STAT_LAST_FREE;
          end else begin
            res_granted_d = 1'b1;
            res_cpu_d     = tgt_q;
          end
        end else if (nfree_q == '0) begin
          res_stat_d = STAT_NONE;
        end else if (nfree_q == CNT_W'(1)) begin
          res_stat_d = STAT_LAST_FREE;
        end else begin
          res_granted_d = 1'b1;
          res_cpu_d     = lowest_idx(pick);
        end
        if (res_granted_d) begin
          nxt = map_x | (MASK_W'(1) << res_cpu_d);
        end
      end
      OP_RELEASE: begin
        if (tgt_ok && map_x[tgt_q]) begin
          nxt       = map_x & ~(MASK_W'(1) << tgt_q);
          res_rel_d = CNT_W'(1);
        end
      end
      OP_RELEASE_ALL: begin
        res_rel_d = relall_q;
        nxt       = map_x & ~online_x;
      end
      default: ;
    endcase
    res_iso_d = res_granted_d & iso_x[res_cpu_d];
    map_d     = cmd_i.exec ? nxt[NUM_CPUS-1:0] : map_q;
  end

endmodule

`default_nettype wire

// ===== sv/priority_cpu_claim_allocator_unit.sv =====
// an item is latched on accept, then goes through pre-count lanes, pre-count sum, decide/update,
//   post-count lanes and post-count sum into the output register; no new item is taken until then;
//   the two popcount passes (before and after) are each the 8-lane partial count and its lane sum
// a result still waiting on the output holds the next one in its last step
// reset: claimed map cleared, online mask = resource 0 only, isolated mask = 0,
//   no result pending; config writes are taken in any cycle
`default_nettype none

module priority_cpu_claim_allocator_unit
  import pcca_pkg::*;
#(
  parameter int unsigned NUM_CPUS = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // config write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [MASK_W-1:0]    cfg_data_i,
  // input item
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [OP_W-1:0]      op_i,
  input  wire logic                 has_request_i,
  input  wire logic [CPU_W-1:0]     target_cpu_i,
  input  wire logic                 prefer_isolated_i,
  input  wire logic                 avoid_first_cpu_i,
  // result item
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      granted_o,
  output logic [CPU_W-1:0]          granted_cpu_o,
  output logic                      on_isolated_cpu_o,
  output logic [STAT_W-1:0]         status_o,
  output logic [CNT_W-1:0]          free_after_o,
  output logic [CNT_W-1:0]          released_count_o
);

  pcca_cmd_t cmd;

  // masks are plain registers, always writable
  assign cfg_ready_o = 1'b1;

  // sequencer: idle -> pre-count lanes -> pre-count sum -> decide/update
  //   -> post-count lanes -> post-count sum and result load
  pcca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // claimed map, masks, counters, priority pick and the output register
  pcca_datapath #(
    .NUM_CPUS (NUM_CPUS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_valid_i & cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .op_i              (op_i),
    .has_request_i     (has_request_i),
    .target_cpu_i      (target_cpu_i),
    .prefer_isolated_i (prefer_isolated_i),
    .avoid_first_cpu_i (avoid_first_cpu_i),
    .granted_o         (granted_o),
    .granted_cpu_o     (granted_cpu_o),
    .on_isolated_cpu_o (on_isolated_cpu_o),
    .status_o          (status_o),
    .free_after_o      (free_after_o),
    .released_count_o  (released_count_o)
  );

  // one item in flight: no second accept right after one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in flight");

  // a grant always reports ok status
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && granted_o |-> status_o == STAT_OK)
    else $error("grant with error status");

  // no grant means no resource index and no isolated flag
  a_no_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !granted_o |-> granted_cpu_o == '0 && !on_isolated_cpu_o)
    else $error("resource reported without a grant");

  // free count never exceeds the resource count
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> free_after_o <= CNT_W'(NUM_CPUS))
    else $error("free count out of range");

endmodule

`default_nettype wire

// ===== test/tb_priority_cpu_claim_allocator_unit.sv =====
module tb_priority_cpu_claim_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pcca_pkg::*;

  localparam int unsigned NCPU = 64;
  // op code the block leaves unused, still legal on the port
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  // cycles with no handshake at all before the run is called hung
  localparam int unsigned STALL_LIMIT = 4000;
  // pause after the last result, a bit above the block's latency
  localparam int unsigned DRAIN_WAIT = 10;
  // long receiver hold-off so the block backs up into its input
  localparam int unsigned HOLD_OFF = 300;
  localparam int unsigned MAX_GAP = 40;

  // one request item as it crosses the input handshake
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             has_req;
    logic [CPU_W-1:0] target;
    logic             pref_iso;
    logic             avoid0;
  } alloc_req_t;

  // one result item, field order matches the output ports
  typedef struct packed {
    logic              granted;
    logic [CPU_W-1:0]  cpu;
    logic              iso;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  free_after;
    logic [CNT_W-1:0]  released;
  } alloc_res_t;

  // shadow of the claim bitmap and masks, plus the outcomes still owed
  class claim_tracker;
    logic [MASK_W-1:0] online;
    logic [MASK_W-1:0] isolated;
    logic [MASK_W-1:0] claimed;
    alloc_res_t        due_outcomes[$];
    int unsigned       errors;

    function new();
      online   = 64'd1;
      isolated = '0;
      claimed  = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] data);
      case (idx)
        REG_ONLINE:   online = data;
        REG_ISOLATED: isolated = data;
        default: ;
      endcase
    endfunction

    function logic [CPU_W-1:0] first_set(logic [MASK_W-1:0] v);
      int unsigned idx;
      idx = 0;
      while (idx < MASK_W - 1 && !v[idx]) idx++;
      return CPU_W'(idx);
    endfunction

    // applies one request to the shadow state and returns what the block owes
    function alloc_res_t grant_outcome(alloc_req_t r);
      logic [MASK_W-1:0] avail;
      logic [MASK_W-1:0] pick;
      int unsigned       nfree;
      alloc_res_t        res;
      res   = '0;
      avail = online & ~claimed;
      nfree = $countones(avail);
      case (r.op)
        OP_CLAIM: begin
          if (r.has_req) begin
            if (!online[r.target]) res.status = STAT_NOT_ONLINE;
            else if (claimed[r.target]) res.status = STAT_CLAIMED;
            else if (nfree < 2) res.status = STAT_LAST_FREE;
            else begin
              res.granted = 1'b1;
              res.cpu = r.target;
            end
          end else if (nfree == 0) begin
            res.status = STAT_NONE;
          end else if (nfree == 1) begin
            res.status = STAT_LAST_FREE;
          end else begin
            pick = '0;
            if (r.pref_iso) pick = avail & isolated;
            if (pick == '0) pick = r.avoid0 ? (avail & ~64'd1) : avail;
            if (pick == '0) pick = avail;
            res.granted = 1'b1;
            res.cpu = first_set(pick);
          end
          if (res.granted) begin
            claimed[res.cpu] = 1'b1;
            res.iso = isolated[res.cpu];
          end
        end
        OP_RELEASE: begin
          if (claimed[r.target]) begin
            claimed[r.target] = 1'b0;
            res.released = CNT_W'(1);
          end
        end
        OP_RELEASE_ALL: begin
          res.released = CNT_W'($countones(claimed & online));
          claimed = claimed & ~online;
        end
        default: ;
      endcase
      res.free_after = CNT_W'($countones(online & ~claimed));
      return res;
    endfunction

    function void note(alloc_req_t r);
      due_outcomes.insert(due_outcomes.size(), grant_outcome(r));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check(alloc_res_t got);
      alloc_res_t want;
      if (due_outcomes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = due_outcomes.pop_front();
        compare_field("granted", 8'(want.granted), 8'(got.granted));
        compare_field("granted_cpu", 8'(want.cpu), 8'(got.cpu));
        compare_field("on_isolated_cpu", 8'(want.iso), 8'(got.iso));
        compare_field("status", 8'(want.status), 8'(got.status));
        compare_field("free_after", 8'(want.free_after), 8'(got.free_after));
        compare_field("released_count", 8'(want.released), 8'(got.released));
      end
    endfunction

    function int unsigned pending();
      return due_outcomes.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [MASK_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [OP_W-1:0]      op_i = '0;
  logic                 has_request_i = 1'b0;
  logic [CPU_W-1:0]     target_cpu_i = '0;
  logic                 prefer_isolated_i = 1'b0;
  logic                 avoid_first_cpu_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 granted_o;
  logic [CPU_W-1:0]     granted_cpu_o;
  logic                 on_isolated_cpu_o;
  logic [STAT_W-1:0]    status_o;
  logic [CNT_W-1:0]     free_after_o;
  logic [CNT_W-1:0]     released_count_o;

  claim_tracker ledger = new();

  // percent chance per cycle that the sender sits idle / the receiver stalls
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  // remaining cycles of a forced receiver hold-off
  int unsigned hold_left = 0;
  // cycles since the last handshake on any channel
  int unsigned quiet = 0;

  priority_cpu_claim_allocator_unit #(
    .NUM_CPUS(NCPU)
  ) u_dut (.*);

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result monitor, values seen here are the ones before this edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      ledger.check({granted_o, granted_cpu_o, on_isolated_cpu_o, status_o,
                    free_after_o, released_count_o});
    end
  end

  // watchdog on lack of progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else if (rst_ni) begin
      quiet = quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no progress, %0d results outstanding", $time, ledger.pending());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // offer one item after a random gap, hold it until taken
  task automatic send(alloc_req_t r);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    op_i              <= r.op;
    has_request_i     <= r.has_req;
    target_cpu_i      <= r.target;
    prefer_isolated_i <= r.pref_iso;
    avoid_first_cpu_i <= r.avoid0;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.note(r);
  endtask

  task automatic put(logic [OP_W-1:0] op, logic hr, logic [CPU_W-1:0] tgt, logic pi, logic av);
    send(alloc_req_t'{op, hr, tgt, pi, av});
  endtask

  // stop offering and let every owed result come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // cfg valid stays up across back-to-back writes, lowered by the caller
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.write_reg(idx, data);
  endtask

  task automatic set_masks(logic [MASK_W-1:0] online, logic [MASK_W-1:0] iso);
    settle();
    write_reg(REG_ONLINE, online);
    write_reg(REG_ISOLATED, iso);
    cfg_valid_i <= 1'b0;
  endtask

  // random member of a mask, any index when the mask is empty
  function automatic logic [CPU_W-1:0] any_bit_of(logic [MASK_W-1:0] m);
    int unsigned k;
    if (m == '0) return CPU_W'($urandom_range(NCPU - 1));
    k = $urandom_range($countones(m) - 1);
    for (int i = 0; i < MASK_W; i++) begin
      if (m[i]) begin
        if (k == 0) return CPU_W'(i);
        k--;
      end
    end
    return '0;
  endfunction

  function automatic logic [MASK_W-1:0] sparse_mask(int unsigned n);
    logic [MASK_W-1:0] m;
    m = '0;
    repeat (n) m[$urandom_range(NCPU - 1)] = 1'b1;
    return m;
  endfunction

  // mostly claims and releases aimed at live resources, some noise
  function automatic alloc_req_t rand_req(int unsigned claim_pct);
    alloc_req_t  r;
    int unsigned roll;
    r.has_req  = ($urandom_range(99) < 35);
    r.pref_iso = 1'($urandom_range(1));
    r.avoid0   = 1'($urandom_range(1));
    r.target   = CPU_W'($urandom_range(NCPU - 1));
    roll = $urandom_range(99);
    if (roll < claim_pct) begin
      r.op = OP_CLAIM;
      if (r.has_req && $urandom_range(3) != 0) r.target = any_bit_of(ledger.online);
    end else if (roll < 94) begin
      r.op = OP_RELEASE;
      if ($urandom_range(3) != 0) r.target = any_bit_of(ledger.claimed);
    end else if (roll < 98) begin
      r.op = OP_RELEASE_ALL;
    end else begin
      r.op = OP_SPARE;
    end
    return r;
  endfunction

  task automatic run_phase(logic [MASK_W-1:0] online, logic [MASK_W-1:0] iso,
                           int unsigned idle, int unsigned stall, int unsigned n,
                           int unsigned claim_pct, bit hold);
    set_masks(online, iso);
    idle_pct  = idle;
    stall_pct = stall;
    if (hold) hold_left = HOLD_OFF;
    repeat (n) send(rand_req(claim_pct));
  endtask

  initial begin
    logic [MASK_W-1:0] m;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: only resource 0 online, so it is always the last free one
    put(OP_CLAIM, 1'b0, 6'd0, 1'b0, 1'b0);
    put(OP_CLAIM, 1'b1, 6'd0, 1'b0, 1'b0);
    put(OP_CLAIM, 1'b1, 6'd5, 1'b0, 1'b0);
    put(OP_RELEASE, 1'b0, 6'd0, 1'b0, 1'b0);
    put(OP_SPARE, 1'b1, 6'd63, 1'b1, 1'b1);
    put(OP_RELEASE_ALL, 1'b0, 6'd0, 1'b0, 1'b0);

    // everything online: auto picks with and without skipping resource 0
    set_masks('1, '0);
    put(OP_CLAIM, 1'b0, 6'd0, 1'b0, 1'b1);
    put(OP_CLAIM, 1'b0, 6'd0, 1'b0, 1'b0);
    put(OP_CLAIM, 1'b1, 6'd63, 1'b0, 1'b0);
    put(OP_CLAIM, 1'b1, 6'd63, 1'b0, 1'b0);
    put(OP_RELEASE, 1'b0, 6'd63, 1'b0, 1'b0);
    put(OP_RELEASE, 1'b0, 6'd63, 1'b0, 1'b0);
    put(OP_CLAIM, 1'b1, 6'd0, 1'b0, 1'b0);
    put(OP_RELEASE_ALL, 1'b0, 6'd0, 1'b0, 1'b0);

    // three online, top one isolated: isolated first, then last free held back
    set_masks(64'h8000_0000_0000_0021, 64'h8000_0000_0000_0000);
    put(OP_CLAIM, 1'b0, 6'd0, 1'b1, 1'b1);
    put(OP_CLAIM, 1'b0, 6'd0, 1'b0, 1'b1);
    put(OP_CLAIM, 1'b0, 6'd0, 1'b1, 1'b0);
    put(OP_CLAIM, 1'b1, 6'd0, 1'b0, 1'b0);
    put(OP_CLAIM, 1'b1, 6'd5, 1'b0, 1'b0);

    // take resource 5 offline while claimed: release-all skips it, release clears it
    set_masks(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000);
    put(OP_RELEASE_ALL, 1'b0, 6'd0, 1'b0, 1'b0);
    put(OP_RELEASE, 1'b0, 6'd5, 1'b0, 1'b0);
    put(OP_CLAIM, 1'b1, 6'd5, 1'b0, 1'b0);

    // nothing online at all
    set_masks('0, '1);
    put(OP_CLAIM, 1'b0, 6'd0, 1'b1, 1'b1);
    put(OP_CLAIM, 1'b1, 6'd0, 1'b0, 1'b0);

    // random phases: mask shapes and idling patterns vary per phase
    run_phase('1, {$urandom, $urandom}, 0, 0, 150, 60, 1'b0);
    m = sparse_mask(6);
    run_phase(m, m & {$urandom, $urandom}, 76, 0, 150, 60, 1'b0);
    // receiver holds off at the start while the sender keeps pushing
    m = sparse_mask(4);
    run_phase(m, {$urandom, $urandom}, 0, 76, 150, 60, 1'b1);
    run_phase('1, '1, 30, 30, 150, 75, 1'b0);
    run_phase({$urandom, $urandom}, '0, 0, 0, 150, 60, 1'b0);
    m = sparse_mask(3);
    run_phase(m, sparse_mask(2) | (m & {$urandom, $urandom}), 30, 76, 100, 65, 1'b0);
    run_phase('0, '0, 76, 30, 50, 60, 1'b0);

    settle();
    if (ledger.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pcca_pkg.sv
sv/pcca_ctrl.sv
sv/pcca_datapath.sv
sv/priority_cpu_claim_allocator_unit.sv
test/tb_priority_cpu_claim_allocator_unit.sv
